// ===== design/pattern_weighted_reflector_element_macros.svh =====
// assertion macros for the pattern weighted reflector element
`ifndef PATTERN_WEIGHTED_REFLECTOR_ELEMENT_MACROS_SVH
`define PATTERN_WEIGHTED_REFLECTOR_ELEMENT_MACROS_SVH

// property checked on every rising edge outside reset
`define PWRE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in this cycle implies a condition in the next cycle
`define PWRE_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== design/pwre_pkg.sv =====
// shared types and constants for the pattern weighted reflector element
`default_nettype none

package pwre_pkg;

    localparam int IDX_W          = 10;
    localparam int QC_W           = 4;
    localparam int GAMMA_W        = 17;
    localparam int ELEM_W         = 18;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 17;
    localparam int DEF_MAX_QUBITS = 10;

    localparam logic [GAMMA_W-1:0]   ONE_Q16     = GAMMA_W'(65536);
    localparam logic [QC_W-1:0]      QUBITS_RST  = QC_W'(1);
    localparam logic [GAMMA_W-1:0]   GAMMA_RST   = GAMMA_W'(16384);
    localparam logic [IDX_W-1:0]     PATTERN_RST = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUBITS  = 2'd0,
        CFG_GAMMA   = 2'd1,
        CFG_PATTERN = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_CROSS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic take;
    } t_eng_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_sts;

endpackage

`default_nettype wire

// ===== design/pwre_engine.sv =====
// sequenced datapath: shared multiplier and square root step for one element
`default_nettype none

module pwre_engine import pwre_pkg::*; #(
    parameter int MAX_QUBITS = DEF_MAX_QUBITS,
    localparam int N_W = $clog2(MAX_QUBITS + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_eng_ctl                 i_ctl,
    output t_eng_sts                      o_sts,
    input  wire logic [IDX_W-1:0]         i_row,
    input  wire logic [IDX_W-1:0]         i_col,
    input  wire logic [IDX_W-1:0]         i_pattern,
    input  wire logic [IDX_W-1:0]         i_mask,
    input  wire logic [N_W-1:0]           i_n,
    input  wire logic [GAMMA_W-1:0]       i_gamma,
    output logic signed [ELEM_W-1:0]      o_elem
);

    localparam int P_W    = 33;
    localparam int RES_W  = 34;
    localparam int AMP_W  = 17;
    localparam int PROD_W = P_W + GAMMA_W;
    localparam int HW_W   = $clog2(IDX_W + 1);
    localparam int E_W    = ELEM_W + 2;

    localparam logic [P_W-1:0]        ONE_P    = P_W'(64'h1_0000_0000);
    localparam logic signed [E_W-1:0] ELEM_MAX = E_W'(65536);
    localparam logic signed [E_W-1:0] ELEM_MIN = -E_W'(65536);

    t_state                    r_state, n_state;
    logic [IDX_W-1:0]          r_row, n_row, r_col, n_col;
    logic                      r_side, n_side;
    logic [N_W-1:0]            r_i, n_i;
    logic [P_W-1:0]            r_p, n_p;
    logic [P_W-1:0]            r_v, n_v;
    logic [RES_W-1:0]          r_res, n_res;
    logic [P_W-1:0]            r_bit, n_bit;
    logic [AMP_W-1:0]          r_ar, n_ar, r_ac, n_ac;
    logic signed [ELEM_W-1:0]  r_elem, n_elem;

    logic [IDX_W-1:0]          diff;
    logic [HW_W-1:0]           ham_dist;
    logic [GAMMA_W-1:0]        og;
    logic [GAMMA_W-1:0]        factor;
    logic [P_W-1:0]            mul_a;
    logic [GAMMA_W-1:0]        mul_b;
    logic [PROD_W-1:0]         prod;
    logic [P_W:0]              prod_shr;
    logic [RES_W:0]            trial;
    logic                      fits;
    logic [RES_W-1:0]          res_step;
    logic                      diag;
    logic [AMP_W-1:0]          cross_term;
    logic signed [E_W-1:0]     elem_w;

    // distance to the pattern for the side in progress
    always_comb begin
        diff = ((r_side ? r_col : r_row) ^ i_pattern) & i_mask;
        ham_dist = '0;
        for (int k = 0; k < IDX_W; k++) begin
            ham_dist = ham_dist + HW_W'(diff[k]);
        end
    end

    // shared multiplier
    always_comb begin
        og     = ONE_Q16 - i_gamma;
        factor = (r_i < ham_dist) ? i_gamma : og;
        if (r_state == ST_CROSS) begin
            mul_a = P_W'(r_ar);
            mul_b = r_ac;
        end else begin
            mul_a = r_p;
            mul_b = factor;
        end
        prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
        prod_shr = prod[PROD_W-1:16];
    end

    // one square root step
    always_comb begin
        trial = (RES_W + 1)'(r_res) + (RES_W + 1)'(r_bit);
        fits  = (RES_W + 1)'(r_v) >= trial;
        if (fits) begin
            res_step = (r_res >> 1) + RES_W'(r_bit);
        end else begin
            res_step = r_res >> 1;
        end
    end

    // element and saturation
    always_comb begin
        diag       = (r_row == r_col);
        cross_term = prod_shr[AMP_W-1:0];
        elem_w     = (diag ? ELEM_MAX : '0) - $signed({2'b00, cross_term, 1'b0});
        if (elem_w > ELEM_MAX) begin
            elem_w = ELEM_MAX;
        end else if (elem_w < ELEM_MIN) begin
            elem_w = ELEM_MIN;
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_side  = r_side;
        n_i     = r_i;
        n_p     = r_p;
        n_v     = r_v;
        n_res   = r_res;
        n_bit   = r_bit;
        n_ar    = r_ar;
        n_ac    = r_ac;
        n_elem  = r_elem;
        o_sts.busy = (r_state != ST_IDLE);
        o_sts.done = (r_state == ST_DONE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_row   = i_row;
                    n_col   = i_col;
                    n_side  = 1'b0;
                    n_i     = '0;
                    n_p     = ONE_P;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_i == i_n) begin
                    n_v     = r_p;
                    n_res   = '0;
                    n_bit   = ONE_P;
                    n_state = ST_SQRT;
                end else begin
                    n_p = prod_shr[P_W-1:0];
                    n_i = r_i + N_W'(1);
                end
            end
            ST_SQRT: begin
                if (fits) begin
                    n_v = r_v - trial[P_W-1:0];
                end
                n_res = res_step;
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    if (!r_side) begin
                        n_ar    = res_step[AMP_W-1:0];
                        n_side  = 1'b1;
                        n_i     = '0;
                        n_p     = ONE_P;
                        n_state = ST_MUL;
                    end else begin
                        n_ac    = res_step[AMP_W-1:0];
                        n_state = ST_CROSS;
                    end
                end
            end
            ST_CROSS: begin
                n_elem  = elem_w[ELEM_W-1:0];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_ctl.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_side <= n_side;
        r_i    <= n_i;
        r_p    <= n_p;
        r_v    <= n_v;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_ar   <= n_ar;
        r_ac   <= n_ac;
        r_elem <= n_elem;
    end

    assign o_elem = r_elem;

endmodule

`default_nettype wire

// ===== design/pattern_weighted_reflector_element.sv =====
// one request at a time, n the effective qubit count: the input stalls until the
// result moves to the output register; the single multiplier runs n times per
// index and once for the cross term, the 17 step square root once per index; a
// finished result waits in the output register while the next request is taken
// reset is synchronous, active low; registers return to n=1, gamma=0.25, pattern 0
`default_nettype none

module pattern_weighted_reflector_element import pwre_pkg::*; #(
    parameter int MAX_QUBITS = DEF_MAX_QUBITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [IDX_W-1:0]         i_row_index,
    input  wire logic [IDX_W-1:0]         i_column_index,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [ELEM_W-1:0]      o_element_value,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int N_W = $clog2(MAX_QUBITS + 1);

    logic [QC_W-1:0]          r_qubits;
    logic [GAMMA_W-1:0]       r_gamma;
    logic [IDX_W-1:0]         r_pattern;
    logic                     r_out_valid;
    logic signed [ELEM_W-1:0] r_out_elem;

    logic [N_W-1:0]           n_eff;
    logic [GAMMA_W-1:0]       gamma_eff;
    logic [IDX_W-1:0]         mask;
    t_eng_ctl                 ctl;
    t_eng_sts                 sts;
    logic signed [ELEM_W-1:0] elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubits  <= QUBITS_RST;
            r_gamma   <= GAMMA_RST;
            r_pattern <= PATTERN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_QUBITS:  r_qubits  <= i_cfg_data[QC_W-1:0];
                CFG_GAMMA:   r_gamma   <= i_cfg_data[GAMMA_W-1:0];
                CFG_PATTERN: r_pattern <= i_cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp qubit count and gamma, build the index mask
    always_comb begin
        if (r_qubits == '0) begin
            n_eff = N_W'(1);
        end else if (int'(r_qubits) > MAX_QUBITS) begin
            n_eff = N_W'(MAX_QUBITS);
        end else begin
            n_eff = N_W'(r_qubits);
        end
        gamma_eff = (r_gamma > ONE_Q16) ? ONE_Q16 : r_gamma;
        for (int k = 0; k < IDX_W; k++) begin
            mask[k] = (k < int'(n_eff));
        end
    end

    assign ctl.start  = i_in_valid && !sts.busy;
    assign ctl.take   = sts.done && (!r_out_valid || !i_out_stall);
    assign o_in_stall = sts.busy;

    pwre_engine #(
        .MAX_QUBITS (MAX_QUBITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .o_sts     (sts),
        .i_row     (i_row_index & mask),
        .i_col     (i_column_index & mask),
        .i_pattern (r_pattern),
        .i_mask    (mask),
        .i_n       (n_eff),
        .i_gamma   (gamma_eff),
        .o_elem    (elem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.take) begin
            r_out_elem <= elem;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_element_value = r_out_elem;

endmodule

`default_nettype wire

// ===== design/pwre_checker.sv =====
// port level checks for the pattern weighted reflector element, with bind
`default_nettype none
`include "pattern_weighted_reflector_element_macros.svh"

module pwre_checker import pwre_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_stall,
    input wire logic [IDX_W-1:0]         i_row_index,
    input wire logic [IDX_W-1:0]         i_column_index,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic signed [ELEM_W-1:0] o_element_value,
    input wire logic                     i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input wire logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic signed [ELEM_W-1:0] ELEM_HI = ELEM_W'(65536);
    localparam logic signed [ELEM_W-1:0] ELEM_LO = -ELEM_W'(65536);

    // element stays within plus and minus one
    `PWRE_ASSERT(a_elem_range, i_clk, i_rst_n, o_out_valid |-> (o_element_value <= ELEM_HI && o_element_value >= ELEM_LO), "element out of range")

    // a taken request keeps the block busy in the next cycle
    `PWRE_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "request taken while still idle")

    // a stalled result holds
    `PWRE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_element_value), "stalled result changed")

    // a new result only comes out of a request in progress
    `PWRE_ASSERT(a_out_from_work, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result without work")

endmodule

bind pattern_weighted_reflector_element pwre_checker u_pwre_checker (.*);

`default_nettype wire
